### rtl/mscr_pkg.sv
// ============================================================================
// mscr_pkg
// Shared widths, register indexes, reset values and control bundles for the
// marquee scroll offset controller.
// ============================================================================
package mscr_pkg;

   localparam int ELAPSED_W = 16;
   localparam int OFFSET_W  = 16;
   localparam int DISP_W    = 10;
   localparam int TEXT_W    = 16;
   localparam int STEP_W    = 8;
   localparam int PERIOD_W  = 16;
   localparam int PAUSE_W   = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;
   // credit plus one elapsed value never leaves [-65535, 131070]
   localparam int CREDIT_W  = 18;

   typedef logic signed [CREDIT_W-1:0] credit_type;

   localparam credit_type CREDIT_MIN = -18'sd65535;
   localparam credit_type CREDIT_MAX = 18'sd65535;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DISPLAY_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_WIDTH    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PIXELS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_PERIOD   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RESTART_MODE  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PAUSE_MS      = 3'd5;

   // reset values
   localparam logic [DISP_W-1:0]   RST_DISPLAY_WIDTH = 10'd128;
   localparam logic [TEXT_W-1:0]   RST_TEXT_WIDTH    = 16'd0;
   localparam logic [STEP_W-1:0]   RST_STEP_PIXELS   = 8'd1;
   localparam logic [PERIOD_W-1:0] RST_STEP_PERIOD   = 16'd1;
   localparam logic                RST_RESTART_MODE  = 1'b0;
   localparam logic [PAUSE_W-1:0]  RST_PAUSE_MS      = 16'd0;

   typedef struct packed {
      logic [DISP_W-1:0]   display_width;
      logic [TEXT_W-1:0]   text_width;
      logic [STEP_W-1:0]   step_pixels;
      logic [PERIOD_W-1:0] step_period_ms;
      logic                restart_mode;
      logic [PAUSE_W-1:0]  pause_ms;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;    // capture credit plus elapsed time
      logic step;    // run one scroll step, consume one period
      logic commit;  // close the update, fill the result register
      logic ran;     // this update ran its step loop
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic run_go;  // credit strictly above the period
      logic more;    // credit still holds a whole period
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_STEP   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

### rtl/mscr_req_if.sv
// ============================================================================
// mscr_req_if
// Request channel: one update carrying the elapsed milliseconds.
// ============================================================================
interface mscr_req_if
   import mscr_pkg::*;
();

   logic                 valid;
   logic                 ready;
   logic [ELAPSED_W-1:0] elapsed_ms;

   modport source (output valid, output elapsed_ms, input ready);
   modport sink   (input valid, input elapsed_ms, output ready);

endinterface

### rtl/mscr_rsp_if.sv
// ============================================================================
// mscr_rsp_if
// Response channel: scroll offset, direction and pause flag.
// ============================================================================
interface mscr_rsp_if
   import mscr_pkg::*;
();

   logic                valid;
   logic                ready;
   logic [OFFSET_W-1:0] offset;
   logic                moving_back;
   logic                paused;

   modport source (output valid, output offset, output moving_back, output paused,
                   input ready);
   modport sink   (input valid, input offset, input moving_back, input paused,
                   output ready);

endinterface

### rtl/marquee_scroll_offset_controller_unit.sv
// ============================================================================
// marquee_scroll_offset_controller_unit
// Bouncing marquee scroll offset controller: time credit, step loop and
// end-of-travel pause, one response per update.
// ============================================================================
// Steps: an update runs N steps (N = credit / period, credit > period) and none
//   otherwise; one step per cycle, N up to 65536.
// A new update is accepted only after the previous one commits; finish waits
//   while the result register is full.
// Reset: synchronous; offset, direction, pause flag and credit clear, the
//   registers take their documented defaults. No clearing pass.
module marquee_scroll_offset_controller_unit
   import mscr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mscr_req_if.sink              req_ch,
   mscr_rsp_if.source            rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   // configuration registers; the user must write them only while idle, the block does not enforce it
   mscr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer: take one request, loop steps, commit into the result register;
   // the next request is taken while a result still waits for its transfer
   mscr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // credit, position and step unit; holds the response payload
   mscr_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .elapsed_ms      (req_ch.elapsed_ms),
      .status          (status),
      .rsp_offset      (rsp_ch.offset),
      .rsp_moving_back (rsp_ch.moving_back),
      .rsp_paused      (rsp_ch.paused)
   );

endmodule

### rtl/mscr_csr.sv
// ============================================================================
// mscr_csr
// Configuration register file, written by index, no read-back.
// ============================================================================
module mscr_csr
   import mscr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DISPLAY_WIDTH: cfg_in.display_width  = csr_wdata[DISP_W-1:0];
            CSR_TEXT_WIDTH:    cfg_in.text_width     = csr_wdata[TEXT_W-1:0];
            CSR_STEP_PIXELS:   cfg_in.step_pixels    = csr_wdata[STEP_W-1:0];
            CSR_STEP_PERIOD:   cfg_in.step_period_ms = csr_wdata[PERIOD_W-1:0];
            CSR_RESTART_MODE:  cfg_in.restart_mode   = csr_wdata[0];
            CSR_PAUSE_MS:      cfg_in.pause_ms       = csr_wdata[PAUSE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.display_width  <= RST_DISPLAY_WIDTH;
         cfg_ff.text_width     <= RST_TEXT_WIDTH;
         cfg_ff.step_pixels    <= RST_STEP_PIXELS;
         cfg_ff.step_period_ms <= RST_STEP_PERIOD;
         cfg_ff.restart_mode   <= RST_RESTART_MODE;
         cfg_ff.pause_ms       <= RST_PAUSE_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/mscr_dp.sv
// ============================================================================
// mscr_dp
// Datapath: time credit, scroll position, direction, pause flag, one step
// unit and the result register.
// ============================================================================
module mscr_dp
   import mscr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  cfg_type              cfg,
   input  cmd_type              cmd,
   input  logic [ELAPSED_W-1:0] elapsed_ms,
   output status_type           status,
   output logic [OFFSET_W-1:0]  rsp_offset,
   output logic                 rsp_moving_back,
   output logic                 rsp_paused
);

   credit_type          credit_ff, credit_in;
   credit_type          ms_ff, ms_in;
   logic [OFFSET_W-1:0] pos_ff, pos_in;
   logic                dir_ff, dir_in;
   logic                pflag_ff, pflag_in;
   logic                hit_ff, hit_in;
   logic [OFFSET_W-1:0] out_offset_ff, out_offset_in;
   logic                out_back_ff, out_back_in;
   logic                out_paused_ff, out_paused_in;

   logic [PERIOD_W-1:0] period;
   credit_type          period_s;
   credit_type          pause_s;
   logic                wide;
   logic                at_left;
   logic                at_right;
   logic [CREDIT_W-1:0] reach;
   logic [OFFSET_W:0]   pos_plus_disp;
   logic [OFFSET_W-1:0] pos_step;

   // a zero period counts as one
   assign period   = (cfg.step_period_ms == '0) ? PERIOD_W'(1) : cfg.step_period_ms;
   assign period_s = $signed({{(CREDIT_W-PERIOD_W){1'b0}}, period});
   assign pause_s  = $signed({{(CREDIT_W-PAUSE_W){1'b0}}, cfg.pause_ms});
   assign wide     = cfg.text_width > {{(TEXT_W-DISP_W){1'b0}}, cfg.display_width};

   assign status.run_go = ms_ff > period_s;
   assign status.more   = ms_ff >= period_s;

   // end detection for one step
   assign pos_plus_disp = {1'b0, pos_ff} + {{(OFFSET_W+1-DISP_W){1'b0}}, cfg.display_width};
   assign at_left = dir_ff && (pos_ff < {{(OFFSET_W-STEP_W){1'b0}}, cfg.step_pixels});
   assign reach = dir_ff
      ? {1'b0, pos_plus_disp} - {{(CREDIT_W-STEP_W){1'b0}}, cfg.step_pixels}
      : {1'b0, pos_plus_disp} + {{(CREDIT_W-STEP_W){1'b0}}, cfg.step_pixels};
   assign at_right = reach > {{(CREDIT_W-TEXT_W){1'b0}}, cfg.text_width};

   // position after a plain step, used only when neither end is reached
   assign pos_step = dir_ff
      ? pos_ff - {{(OFFSET_W-STEP_W){1'b0}}, cfg.step_pixels}
      : pos_ff + {{(OFFSET_W-STEP_W){1'b0}}, cfg.step_pixels};

   always_comb begin
      credit_in     = credit_ff;
      ms_in         = ms_ff;
      pos_in        = pos_ff;
      dir_in        = dir_ff;
      pflag_in      = pflag_ff;
      hit_in        = hit_ff;
      out_offset_in = out_offset_ff;
      out_back_in   = out_back_ff;
      out_paused_in = out_paused_ff;

      if (cmd.load) begin
         ms_in  = credit_ff + $signed({{(CREDIT_W-ELAPSED_W){1'b0}}, elapsed_ms});
         hit_in = 1'b0;
      end

      if (cmd.step) begin
         ms_in = ms_ff - period_s;
         if (wide) begin
            priority if (at_left) begin
               pos_in = '0;
               dir_in = ~dir_ff;
               if (pflag_ff) pflag_in = 1'b0;
               else          hit_in   = 1'b1;
            end else if (at_right) begin
               if (!cfg.restart_mode) begin
                  pos_in = cfg.text_width - {{(TEXT_W-DISP_W){1'b0}}, cfg.display_width};
                  dir_in = ~dir_ff;
               end
               if (pflag_ff) begin
                  pflag_in = 1'b0;
                  if (cfg.restart_mode) pos_in = '0;
               end else begin
                  hit_in = 1'b1;
               end
            end else begin
               pos_in = pos_step;
            end
         end
      end

      if (cmd.commit) begin
         credit_in = ms_ff;
         if (cmd.ran) begin
            pflag_in = hit_ff;
            if (hit_ff) credit_in = ms_ff - pause_s;
         end
         out_offset_in = pos_ff;
         out_back_in   = dir_ff;
         out_paused_in = cmd.ran ? hit_ff : pflag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
         pos_ff    <= '0;
         dir_ff    <= 1'b0;
         pflag_ff  <= 1'b0;
      end else begin
         credit_ff <= credit_in;
         pos_ff    <= pos_in;
         dir_ff    <= dir_in;
         pflag_ff  <= pflag_in;
      end
   end

   always_ff @(posedge clock) begin
      ms_ff         <= ms_in;
      hit_ff        <= hit_in;
      out_offset_ff <= out_offset_in;
      out_back_ff   <= out_back_in;
      out_paused_ff <= out_paused_in;
   end

   assign rsp_offset      = out_offset_ff;
   assign rsp_moving_back = out_back_ff;
   assign rsp_paused      = out_paused_ff;

   a_credit_range: assert property (@(posedge clock) disable iff (reset)
      credit_ff >= CREDIT_MIN && credit_ff <= CREDIT_MAX)
      else $error("time credit out of range");

   a_pos_hold: assert property (@(posedge clock) disable iff (reset)
      !cmd.step |=> $stable(pos_ff) && $stable(dir_ff))
      else $error("scroll position moved without a step");

endmodule

### rtl/mscr_ctrl.sv
// ============================================================================
// mscr_ctrl
// Controller: sequences load, step loop and commit for one update, and owns
// the response valid flag.
// ============================================================================
module mscr_ctrl
   import mscr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      ran_ff, ran_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      ran_in       = ran_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      cmd.ran      = ran_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            ran_in   = status.run_go;
            state_in = status.run_go ? ST_STEP : ST_FINISH;
         end
         ST_STEP: begin
            if (status.more) cmd.step = 1'b1;
            else             state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ran_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ran_ff       <= ran_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_to_check: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_CHECK)
      else $error("accepted update did not move to check");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside finish");

   a_finish_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && !out_free |=> state_ff == ST_FINISH && rsp_valid_ff)
      else $error("finish left while result register full");

   a_step_needs_run: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_STEP |-> ran_ff)
      else $error("step loop entered without credit above period");

endmodule
